@@ sv/phx_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Philox-4x32 counter generator: round constants, word types.
// No dependencies; used by phx_round, phx_cfg and philox_counter_rng.
package phx_pkg;

    localparam int ROUND_COUNT = 10;

    localparam logic [31:0] MUL_A  = 32'hd2511f53;
    localparam logic [31:0] MUL_B  = 32'hcd9e8d57;
    localparam logic [31:0] WEYL_A = 32'h9e3779b9;
    localparam logic [31:0] WEYL_B = 32'hbb67ae85;

    localparam int                 PADDR_W       = 4;
    localparam logic [PADDR_W-1:0] REG_SEED_ADDR = PADDR_W'(0);

    // Four counter words of one block.
    typedef struct packed {
        logic [31:0] c3;
        logic [31:0] c2;
        logic [31:0] c1;
        logic [31:0] c0;
    } ctr_t;

    // Two key words used by one round.
    typedef struct packed {
        logic [31:0] k1;
        logic [31:0] k0;
    } key_t;

endpackage

@@ sv/phx_round.sv @@
`timescale 1ns / 1ps
// One Philox round as a pipeline stage: two 32x32 products, swap and key XOR.
// Depends on phx_pkg.
module phx_round
    import phx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  ctr_t in_ctr,
    input  key_t rkey,
    input  logic hold,
    output logic out_valid,
    output ctr_t out_ctr,
    output logic stall
);

    logic        valid_reg;
    logic        valid_next;
    ctr_t        ctr_reg;
    ctr_t        ctr_next;
    logic [63:0] prod_a;
    logic [63:0] prod_b;
    logic        load;

    assign prod_a = 64'(MUL_A) * 64'(in_ctr.c0);
    assign prod_b = 64'(MUL_B) * 64'(in_ctr.c2);

    always_comb
    begin
        ctr_next.c0 = prod_b[63:32] ^ in_ctr.c1 ^ rkey.k0;
        ctr_next.c1 = prod_b[31:0];
        ctr_next.c2 = prod_a[63:32] ^ in_ctr.c3 ^ rkey.k1;
        ctr_next.c3 = prod_a[31:0];
    end

    // Hold only while full and the next stage cannot take the item.
    assign stall      = valid_reg & hold;
    assign load       = ~stall;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            ctr_reg <= ctr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctr   = ctr_reg;

endmodule

@@ sv/phx_cfg.sv @@
`timescale 1ns / 1ps
// APB register file holding the 64-bit seed key.
// Depends on phx_pkg.
module phx_cfg
    import phx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output key_t               seed
);

    logic [63:0] seed_reg;
    logic [63:0] seed_next;
    logic        wr_seed;

    assign pready  = 1'b1;
    assign wr_seed = psel & penable & pwrite & (paddr == REG_SEED_ADDR);

    assign seed_next = wr_seed ? pwdata : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    // Unmapped addresses read as zero.
    assign prdata = (paddr == REG_SEED_ADDR) ? seed_reg : 64'h0;

    assign seed.k0 = seed_reg[31:0];
    assign seed.k1 = seed_reg[63:32];

endmodule

@@ sv/philox_counter_rng.sv @@
`timescale 1ns / 1ps
// Top level of the Philox-4x32 counter generator: round pipeline and seed register.
// Depends on phx_pkg, phx_round and phx_cfg.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, block_index       | request
//  out     | out_valid, out_stall, word_zero..three| result
//  cfg     | APB: psel .. pready, seed key at 0x0  | register
//
// One round per stage, ROUND_COUNT stages: an item passes the stage registers in
// round order, and one item can enter every cycle while in_stall is low.
// Each stage holds the 32x32 multiplier pair of its round.
// A stalled output holds only the full stages; empty stages keep filling,
// so in_stall rises only when every stage holds an item.
// Reset clears all stage valid bits and the seed key.
module philox_counter_rng
    import phx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        block_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        word_zero,
    output logic [31:0]        word_one,
    output logic [31:0]        word_two,
    output logic [31:0]        word_three,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    key_t                   seed;
    logic [ROUND_COUNT:0]   stg_valid;
    ctr_t                   stg_ctr [ROUND_COUNT+1];
    logic [ROUND_COUNT:0]   stg_stall;
    key_t                   rkey [ROUND_COUNT];

    phx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seed    (seed)
    );

    assign stg_valid[0]   = in_valid;
    assign stg_ctr[0].c0  = block_index[31:0];
    assign stg_ctr[0].c1  = block_index[63:32];
    assign stg_ctr[0].c2  = 32'h0;
    assign stg_ctr[0].c3  = 32'h0;
    assign stg_stall[ROUND_COUNT] = out_stall;

    genvar r;
    generate
        for (r = 0; r < ROUND_COUNT; r++)
        begin : g_round
            // Key of round r is the seed advanced r times by the Weyl constants.
            localparam logic [63:0] OFS_A = 64'(r) * 64'(WEYL_A);
            localparam logic [63:0] OFS_B = 64'(r) * 64'(WEYL_B);

            assign rkey[r].k0 = seed.k0 + OFS_A[31:0];
            assign rkey[r].k1 = seed.k1 + OFS_B[31:0];

            phx_round u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stg_valid[r]),
                .in_ctr    (stg_ctr[r]),
                .rkey      (rkey[r]),
                .hold      (stg_stall[r+1]),
                .out_valid (stg_valid[r+1]),
                .out_ctr   (stg_ctr[r+1]),
                .stall     (stg_stall[r])
            );
        end
    endgenerate

    assign in_stall   = stg_stall[0];
    assign out_valid  = stg_valid[ROUND_COUNT];
    assign word_zero  = stg_ctr[ROUND_COUNT].c0;
    assign word_one   = stg_ctr[ROUND_COUNT].c1;
    assign word_two   = stg_ctr[ROUND_COUNT].c2;
    assign word_three = stg_ctr[ROUND_COUNT].c3;

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid & ~in_stall;
    assign out_acc = out_valid & ~out_stall;

    // Input backs up only when every stage is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&stg_valid[ROUND_COUNT:1]))
        else $error("input stalled with an empty stage");

    // A free output never blocks the input.
    a_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // Items in flight change only by accepted inputs and delivered results.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(stg_valid[ROUND_COUNT:1]) ==
         $countones($past(stg_valid[ROUND_COUNT:1])) + 32'($past(in_acc))
         - 32'($past(out_acc))))
        else $error("item lost or duplicated in pipeline");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for philox_counter_rng: random and directed block indices under several seeds,
// with idle and stall phases on both channels. Depends on phx_pkg and the RTL top level.
module testbench;
    import phx_pkg::*;

    localparam int                 RESET_CYCLES = 7;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 PHASE_COUNT  = 8;
    localparam int                 PHASE_ITEMS  = 80;
    localparam logic [PADDR_W-1:0] UNUSED_ADDR  = PADDR_W'(8);
    // Published Philox-4x32-10 output for counter zero under key zero.
    localparam ctr_t ZERO_BLOCK_WORDS =
        {32'h9b00dbd8, 32'hbc57ac4c, 32'he169c58d, 32'h6627e8d5};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [63:0]        block_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        word_zero;
    logic [31:0]        word_one;
    logic [31:0]        word_two;
    logic [31:0]        word_three;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    logic [63:0] pending_indices[$];
    ctr_t        expected_blocks[$];
    logic [63:0] seed_shadow = '0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    philox_counter_rng dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_index(block_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_zero  (word_zero),
        .word_one   (word_one),
        .word_two   (word_two),
        .word_three (word_three),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Ten rounds of Philox-4x32 on counter {0, 0, index}; seed low half is key word zero.
    function automatic ctr_t philox_block(input logic [63:0] index, input logic [63:0] seed);
        ctr_t        ctr;
        ctr_t        next;
        key_t        key;
        logic [63:0] prod_a;
        logic [63:0] prod_b;
        ctr    = '0;
        ctr.c0 = index[31:0];
        ctr.c1 = index[63:32];
        key    = seed;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            prod_a  = {32'd0, MUL_A} * {32'd0, ctr.c0};
            prod_b  = {32'd0, MUL_B} * {32'd0, ctr.c2};
            next.c0 = prod_b[63:32] ^ ctr.c1 ^ key.k0;
            next.c1 = prod_b[31:0];
            next.c2 = prod_a[63:32] ^ ctr.c3 ^ key.k1;
            next.c3 = prod_a[31:0];
            ctr     = next;
            key.k0  = key.k0 + WEYL_A;
            key.k1  = key.k1 + WEYL_B;
        end
        return ctr;
    endfunction

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [63:0] data, output logic [63:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (write && addr == REG_SEED_ADDR)
            seed_shadow = data;
    endtask

    task automatic check_seed_readback();
        logic [63:0] rdata;
        apb_access(1'b0, REG_SEED_ADDR, '0, rdata);
        if (rdata !== seed_shadow)
            report_error($sformatf("seed readback %h, want %h", rdata, seed_shadow));
    endtask

    // Hold off until every item is in and out, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_indices.size() != 0 || in_valid || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (ROUND_COUNT + 4) @(posedge clk);
    endtask

    // Driver: predict on acceptance, then offer the next item unless idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_blocks.insert(expected_blocks.size(),
                                       philox_block(block_index, seed_shadow));
            if (!in_valid || !in_stall)
            begin
                if (pending_indices.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    block_index <= pending_indices.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        ctr_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report_error("result with no item pending");
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (word_zero !== want.c0)
                        report_error($sformatf("word_zero %h, want %h", word_zero, want.c0));
                    if (word_one !== want.c1)
                        report_error($sformatf("word_one %h, want %h", word_one, want.c1));
                    if (word_two !== want.c2)
                        report_error($sformatf("word_two %h, want %h", word_two, want.c2));
                    if (word_three !== want.c3)
                        report_error($sformatf("word_three %h, want %h", word_three,
                                               want.c3));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] seed_value;
        logic [63:0] base;
        logic [63:0] unused_rdata;
        int          count;
        int          run_len;

        if (philox_block(64'd0, 64'd0) != ZERO_BLOCK_WORDS)
            report_error("predictor disagrees with the zero-key test vector");

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset seed, no idling: field extremes, single-bit and alternating patterns.
        check_seed_readback();
        pending_indices = '{64'h0, 64'h1, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_ffff_ffff,
                            64'hffff_ffff_0000_0000, 64'h8000_0000_0000_0000,
                            64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000,
                            64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                            64'h0000_0000_ffff_fffe, 64'hffff_fffe_ffff_ffff};
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: seed_value = 64'hffff_ffff_ffff_ffff;
                2: seed_value = 64'h0000_0000_ffff_ffff;
                3: seed_value = 64'hffff_ffff_0000_0000;
                5: seed_value = 64'h0;
                default: seed_value = {$urandom, $urandom};
            endcase
            apb_access(1'b1, REG_SEED_ADDR, seed_value, unused_rdata);
            // A write past the last register must leave the seed alone.
            if (p == 4)
                apb_access(1'b1, UNUSED_ADDR, {$urandom, $urandom}, unused_rdata);
            check_seed_readback();

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 70)
                begin
                    // Consecutive block numbers, as a stream consumer would ask for.
                    case ($urandom_range(3))
                        0: base = {$urandom, 32'hffff_fff0 | 32'($urandom_range(15))};
                        1: base = 64'hffff_ffff_ffff_fff8;
                        default: base = {$urandom, $urandom};
                    endcase
                    run_len = $urandom_range(1, 8);
                    for (int j = 0; j < run_len; j++)
                        pending_indices.insert(pending_indices.size(), base + 64'(j));
                    count += run_len;
                end
                else
                begin
                    base = {$urandom, $urandom};
                    case ($urandom_range(4))
                        0: base[31:0] = '0;
                        1: base[63:32] = '1;
                        2: base = ~base;
                        default: ;
                    endcase
                    pending_indices.insert(pending_indices.size(), base);
                    count++;
                end
            end
            wait_drained();
        end

        if (expected_blocks.size() != 0)
            report_error("predictions left without a result");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
